[design/crc8_frame_parser_top_macros.svh]
// Assertion macros for the CRC-8 frame parser.
// Used by crc8_frame_parser_top; expects i_clk and i_rst_n in scope.
`ifndef CRC8_FRAME_PARSER_TOP_MACROS_SVH
`define CRC8_FRAME_PARSER_TOP_MACROS_SVH

// Property checked on every rising clock edge outside reset
`define CFP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Same-cycle implication
`define CFP_ASSERT_IMP(label, ante, cons, msg) \
    `CFP_ASSERT(label, (ante) |-> (cons), msg)

// Next-cycle implication
`define CFP_ASSERT_NXT(label, ante, cons, msg) \
    `CFP_ASSERT(label, (ante) |=> (cons), msg)

`endif

[design/crcfp_pkg.sv]
// Shared constants and the CRC-8 update function for the frame parser.
// No dependencies.
package crcfp_pkg;

    localparam int MAX_PAYLOAD = 32;
    localparam int ADDR_W      = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int LEN_W       = 6;

    localparam logic [7:0] CRC_POLY   = 8'h07;
    localparam logic [7:0] CRC_INIT   = 8'h00;
    localparam logic [7:0] START_RST  = 8'hAA;

    // Result kinds
    localparam logic [1:0] KIND_CMD = 2'd0;
    localparam logic [1:0] KIND_PAY = 2'd1;
    localparam logic [1:0] KIND_ERR = 2'd2;

    typedef logic [LEN_W-1:0] t_len;

    // CRC-8, MSB first, one byte
    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] v;
        v = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (v[7]) begin
                v = {v[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                v = {v[6:0], 1'b0};
            end
        end
        return v;
    endfunction

endpackage

[design/crcfp_ram.sv]
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module crcfp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[design/crc8_frame_parser_top.sv]
// CRC-8 frame parser top level: parse sequencer, payload store, result register.
// Depends on crcfp_pkg, crcfp_ram and crc8_frame_parser_top_macros.svh.
//
//   channel   dir   handshake            payload
//   in        in    i_in_valid/o_in_stall  i_rx_byte
//   out       out   o_out_valid/i_out_stall o_out_kind, o_out_byte, o_frame_length,
//                                          o_computed_crc, o_last
//   cfg       in    i_cfg_valid/o_cfg_ready i_cfg_data (start byte)
//
// Received bytes are accepted whenever the input does not stall. A CRC byte that matches loads
// the command result; the payload store is then read one entry ahead of the result register,
// so the payload results follow one per cycle while the output does not stall. The input
// stalls until the last result is loaded, and while an earlier result is still held the
// CRC byte also waits. Reset is synchronous, active low, and returns the parser to hunting
// with start byte 0xAA. Output stalls hold the result register and pause the store reads.
`include "crc8_frame_parser_top_macros.svh"

module crc8_frame_parser_top
    import crcfp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // received bytes
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_rx_byte,
    // results
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_out_kind,
    output logic [7:0]  o_out_byte,
    output logic [5:0]  o_frame_length,
    output logic [7:0]  o_computed_crc,
    output logic        o_last,
    // configuration
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data
);

    localparam logic [2:0] PH_HUNT   = 3'd0;
    localparam logic [2:0] PH_LEN_LO = 3'd1;
    localparam logic [2:0] PH_LEN_HI = 3'd2;
    localparam logic [2:0] PH_CMD    = 3'd3;
    localparam logic [2:0] PH_PAY    = 3'd4;
    localparam logic [2:0] PH_CRC    = 3'd5;
    localparam logic [2:0] PH_EMIT   = 3'd6;

    localparam logic [15:0] MAX_LEN16 = 16'(MAX_PAYLOAD);

    // parse state
    logic [2:0] r_phase,   n_phase;
    logic [7:0] r_start;
    logic [7:0] r_len_lo,  n_len_lo;
    t_len       r_exp_len, n_exp_len;
    t_len       r_rcv_cnt, n_rcv_cnt;
    logic [7:0] r_cmd,     n_cmd;
    logic [7:0] r_crc,     n_crc;

    // emit sequencer
    t_len       r_rd_idx,  n_rd_idx;
    logic       r_rd_valid, n_rd_valid;
    logic       r_rd_last,  n_rd_last;

    // result register
    logic       r_out_valid, n_out_valid;
    logic [1:0] r_out_kind,  n_out_kind;
    logic [7:0] r_out_byte,  n_out_byte;
    t_len       r_out_len,   n_out_len;
    logic [7:0] r_out_crc,   n_out_crc;
    logic       r_out_last,  n_out_last;

    logic       in_acc;
    logic       out_load;
    logic       rd_issue;
    logic       rd_move;
    logic       ram_we;
    logic [7:0] ram_q;
    logic [7:0] crc_next;
    t_len       cnt_inc;
    logic [15:0] len16;

    // handshakes
    assign o_in_stall  = (r_phase == PH_EMIT) || ((r_phase == PH_CRC) && r_out_valid);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign out_load    = !r_out_valid || !i_out_stall;
    assign o_cfg_ready = 1'b1;

    // store reads run one ahead of the result register
    assign rd_issue = (r_phase == PH_EMIT) && (r_rd_idx < r_exp_len)
                      && (!r_rd_valid || out_load);
    assign rd_move  = r_rd_valid && out_load;
    assign ram_we   = in_acc && (r_phase == PH_PAY);

    assign crc_next = crc8_update((r_phase == PH_CMD) ? CRC_INIT : r_crc, i_rx_byte);
    assign cnt_inc  = r_rcv_cnt + t_len'(1);
    assign len16    = {i_rx_byte, r_len_lo};

    crcfp_ram #(
        .WIDTH (8),
        .DEPTH (MAX_PAYLOAD)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_rcv_cnt[ADDR_W-1:0]),
        .i_wdata (i_rx_byte),
        .i_re    (rd_issue),
        .i_raddr (r_rd_idx[ADDR_W-1:0]),
        .o_rdata (ram_q)
    );

    // next state
    always_comb begin
        n_phase     = r_phase;
        n_len_lo    = r_len_lo;
        n_exp_len   = r_exp_len;
        n_rcv_cnt   = r_rcv_cnt;
        n_cmd       = r_cmd;
        n_crc       = r_crc;
        n_rd_idx    = r_rd_idx;
        n_rd_valid  = r_rd_valid;
        n_rd_last   = r_rd_last;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_kind  = r_out_kind;
        n_out_byte  = r_out_byte;
        n_out_len   = r_out_len;
        n_out_crc   = r_out_crc;
        n_out_last  = r_out_last;

        if (in_acc) begin
            unique case (r_phase)
                PH_HUNT: begin
                    if (i_rx_byte == r_start) begin
                        n_phase = PH_LEN_LO;
                    end
                end
                PH_LEN_LO: begin
                    n_len_lo = i_rx_byte;
                    n_phase  = PH_LEN_HI;
                end
                PH_LEN_HI: begin
                    if (len16 > MAX_LEN16) begin
                        n_phase  = PH_HUNT;
                        n_len_lo = '0;
                    end else begin
                        n_exp_len = t_len'(len16);
                        n_phase   = PH_CMD;
                    end
                end
                PH_CMD: begin
                    n_cmd     = i_rx_byte;
                    n_rcv_cnt = '0;
                    n_crc     = crc_next;
                    n_phase   = (r_exp_len == '0) ? PH_CRC : PH_PAY;
                end
                PH_PAY: begin
                    n_crc     = crc_next;
                    n_rcv_cnt = cnt_inc;
                    if (cnt_inc >= r_exp_len) begin
                        n_phase = PH_CRC;
                    end
                end
                PH_CRC: begin
                    n_out_valid = 1'b1;
                    n_out_len   = r_exp_len;
                    n_out_crc   = r_crc;
                    if (r_crc == i_rx_byte) begin
                        n_out_kind = KIND_CMD;
                        n_out_byte = r_cmd;
                        n_out_last = (r_exp_len == '0);
                    end else begin
                        n_out_kind = KIND_ERR;
                        n_out_byte = i_rx_byte;
                        n_out_last = 1'b1;
                    end
                    if ((r_crc == i_rx_byte) && (r_exp_len != '0)) begin
                        n_phase    = PH_EMIT;
                        n_rd_idx   = '0;
                        n_rd_valid = 1'b0;
                    end else begin
                        n_phase   = PH_HUNT;
                        n_len_lo  = '0;
                        n_exp_len = '0;
                        n_rcv_cnt = '0;
                        n_cmd     = '0;
                        n_crc     = CRC_INIT;
                    end
                end
                default: begin
                    n_phase   = PH_HUNT;
                    n_len_lo  = '0;
                    n_exp_len = '0;
                    n_rcv_cnt = '0;
                    n_cmd     = '0;
                    n_crc     = CRC_INIT;
                end
            endcase
        end

        // payload run
        if (r_phase == PH_EMIT) begin
            if (rd_move) begin
                n_out_valid = 1'b1;
                n_out_kind  = KIND_PAY;
                n_out_byte  = ram_q;
                n_out_len   = r_exp_len;
                n_out_crc   = r_crc;
                n_out_last  = r_rd_last;
                n_rd_valid  = 1'b0;
                if (r_rd_last) begin
                    n_phase   = PH_HUNT;
                    n_len_lo  = '0;
                    n_exp_len = '0;
                    n_rcv_cnt = '0;
                    n_cmd     = '0;
                    n_crc     = CRC_INIT;
                end
            end
            if (rd_issue) begin
                n_rd_valid = 1'b1;
                n_rd_last  = (r_rd_idx + t_len'(1)) == r_exp_len;
                n_rd_idx   = r_rd_idx + t_len'(1);
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HUNT;
            r_start     <= START_RST;
            r_len_lo    <= '0;
            r_exp_len   <= '0;
            r_rcv_cnt   <= '0;
            r_cmd       <= '0;
            r_crc       <= CRC_INIT;
            r_rd_idx    <= '0;
            r_rd_valid  <= 1'b0;
            r_rd_last   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_len_lo    <= n_len_lo;
            r_exp_len   <= n_exp_len;
            r_rcv_cnt   <= n_rcv_cnt;
            r_cmd       <= n_cmd;
            r_crc       <= n_crc;
            r_rd_idx    <= n_rd_idx;
            r_rd_valid  <= n_rd_valid;
            r_rd_last   <= n_rd_last;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                r_start <= i_cfg_data;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        r_out_kind <= n_out_kind;
        r_out_byte <= n_out_byte;
        r_out_len  <= n_out_len;
        r_out_crc  <= n_out_crc;
        r_out_last <= n_out_last;
    end

    assign o_out_valid    = r_out_valid;
    assign o_out_kind     = r_out_kind;
    assign o_out_byte     = r_out_byte;
    assign o_frame_length = r_out_len;
    assign o_computed_crc = r_out_crc;
    assign o_last         = r_out_last;

    // checks
    `CFP_ASSERT_IMP(a_rd_only_emit, r_rd_valid, r_phase == PH_EMIT, "store read outside run")
    `CFP_ASSERT_IMP(a_rd_idx_range, r_phase == PH_EMIT, r_rd_idx <= r_exp_len, "index > len")
    `CFP_ASSERT_NXT(a_crc_loads_out, in_acc && (r_phase == PH_CRC), o_out_valid, "no result")
    `CFP_ASSERT_IMP(a_err_is_last, o_out_valid && (o_out_kind == KIND_ERR), o_last, "error not last")
    `CFP_ASSERT_IMP(a_len_bound, o_out_valid, o_frame_length <= t_len'(MAX_PAYLOAD), "len > max")

endmodule

[verif/crc8_frame_parser_top_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for crc8_frame_parser_top: directed and random byte streams,
// with a frame parser model inside a small scoreboard class. Depends on crcfp_pkg.
module crc8_frame_parser_top_tb;
    import crcfp_pkg::*;

    localparam int RANDOM_BYTES = 330;
    localparam int SETTLE       = 40;   // settle time after the owed results drain
    localparam int CALM_TAIL    = 50;

    // One result transaction as seen on the output port
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        t_len       len;
        logic [7:0] crc;
        logic       last;
    } frame_result_t;

    typedef enum logic [2:0] {
        SCAN_HUNT, SCAN_LEN_LO, SCAN_LEN_HI, SCAN_CMD, SCAN_BODY, SCAN_CRC
    } scan_phase_e;

    // Frame parser model plus the queue of results still owed by the block
    class frame_checker;
        logic [7:0]    start_val;
        scan_phase_e   phase;
        logic [15:0]   want_len;
        logic [5:0]    got;
        logic [7:0]    cmd;
        logic [7:0]    crc;
        logic [7:0]    body [MAX_PAYLOAD];
        frame_result_t frame_out_due [$];
        int            n_fail;
        int            n_checked;
        int            n_frames;
        int            n_crc_err;

        function new();
            start_val = START_RST;
            n_fail    = 0;
            n_checked = 0;
            n_frames  = 0;
            n_crc_err = 0;
            restart();
        endfunction

        // CRC-8, poly 0x07, fed one input bit at a time, MSB first
        function logic [7:0] crc_step(logic [7:0] c, logic [7:0] b);
            logic fb;
            for (int i = 7; i >= 0; i--) begin
                fb = c[7] ^ b[i];
                c  = {c[6:0], 1'b0} ^ (fb ? 8'h07 : 8'h00);
            end
            return c;
        endfunction

        function void restart();
            phase    = SCAN_HUNT;
            want_len = '0;
            got      = '0;
            cmd      = '0;
            crc      = '0;
        endfunction

        function void set_start(logic [7:0] v);
            start_val = v;
        endfunction

        function void add(logic [1:0] kind, logic [7:0] data, logic last);
            frame_result_t r;
            r.kind = kind;
            r.data = data;
            r.len  = want_len[5:0];
            r.crc  = crc;
            r.last = last;
            frame_out_due.push_back(r);
        endfunction

        // Advance the parser by one accepted byte
        function void parse_byte(logic [7:0] b);
            case (phase)
                SCAN_HUNT: begin
                    if (b == start_val) phase = SCAN_LEN_LO;
                end
                SCAN_LEN_LO: begin
                    want_len = {8'h00, b};
                    phase    = SCAN_LEN_HI;
                end
                SCAN_LEN_HI: begin
                    want_len[15:8] = b;
                    if (want_len > MAX_PAYLOAD) restart();
                    else phase = SCAN_CMD;
                end
                SCAN_CMD: begin
                    cmd   = b;
                    got   = '0;
                    crc   = crc_step(8'h00, b);
                    phase = (want_len == 0) ? SCAN_CRC : SCAN_BODY;
                end
                SCAN_BODY: begin
                    body[got] = b;
                    crc       = crc_step(crc, b);
                    got       = got + 1'b1;
                    if (got >= want_len) phase = SCAN_CRC;
                end
                SCAN_CRC: begin
                    if (crc == b) begin
                        n_frames++;
                        add(KIND_CMD, cmd, want_len == 0);
                        for (int i = 0; i < want_len; i++)
                            add(KIND_PAY, body[i], i + 1 == want_len);
                    end else begin
                        n_crc_err++;
                        add(KIND_ERR, b, 1'b1);
                    end
                    restart();
                end
                default: restart();
            endcase
        endfunction

        function void check_result(frame_result_t act);
            frame_result_t exp;
            n_checked++;
            if (frame_out_due.size() == 0) begin
                $error("unexpected result: kind %0d byte %02h", act.kind, act.data);
                n_fail++;
                return;
            end
            exp = frame_out_due.pop_front();
            if (act.kind !== exp.kind) begin
                $error("out_kind: expected %0d, actual %0d", exp.kind, act.kind);
                n_fail++;
            end
            if (act.data !== exp.data) begin
                $error("out_byte: expected %02h, actual %02h", exp.data, act.data);
                n_fail++;
            end
            if (act.len !== exp.len) begin
                $error("frame_length: expected %0d, actual %0d", exp.len, act.len);
                n_fail++;
            end
            if (act.crc !== exp.crc) begin
                $error("computed_crc: expected %02h, actual %02h", exp.crc, act.crc);
                n_fail++;
            end
            if (act.last !== exp.last) begin
                $error("last: expected %0d, actual %0d", exp.last, act.last);
                n_fail++;
            end
        endfunction

        function int outstanding();
            return frame_out_due.size();
        endfunction
    endclass

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    logic [7:0] i_rx_byte   = 8'h00;
    logic       i_out_stall = 1'b0;
    logic       i_cfg_valid = 1'b0;
    logic [7:0] i_cfg_data  = 8'h00;
    logic       o_in_stall;
    logic       o_out_valid;
    logic [1:0] o_out_kind;
    logic [7:0] o_out_byte;
    logic [5:0] o_frame_length;
    logic [7:0] o_computed_crc;
    logic       o_last;
    logic       o_cfg_ready;

    frame_checker board;
    logic [7:0]   cur_start = START_RST;
    logic [7:0]   rand_start;
    bit           calm      = 1'b0;
    int           gap_pct   = 0;
    int           n_bytes   = 0;

    crc8_frame_parser_top DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_rx_byte      (i_rx_byte),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out_kind     (o_out_kind),
        .o_out_byte     (o_out_byte),
        .o_frame_length (o_frame_length),
        .o_computed_crc (o_computed_crc),
        .o_last         (o_last),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // Run limit
    initial begin
        #4_000_000;
        $display("crc8_frame_parser_top regression: fail");
        $finish;
    end

    // Output monitor: every accepted result transaction goes to the checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            board.check_result(frame_result_t'{o_out_kind, o_out_byte, o_frame_length,
                                               o_computed_crc, o_last});
    end

    // Receiver back-pressure: random stall bursts, quiet stretches, none at the tail
    initial begin
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            if (!calm && $urandom_range(0, 2) != 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 14)) @(negedge i_clk);
                i_out_stall <= 1'b0;
            end
            repeat ($urandom_range(1, 40)) @(negedge i_clk);
        end
    end

    // One byte transaction; called and returns at a falling edge
    task automatic send_byte(input logic [7:0] b);
        if (!calm && $urandom_range(0, 99) < gap_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_rx_byte  <= b;
        do @(posedge i_clk); while (o_in_stall);
        board.parse_byte(b);
        n_bytes++;
        @(negedge i_clk);
    endtask

    // Stop sending, let every owed result drain, then let the block settle
    task automatic drain();
        i_in_valid <= 1'b0;
        while (board.outstanding() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_start(input logic [7:0] v);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.set_start(v);
        cur_start = v;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Start byte, length, then command, body and CRC unless the length is too big
    task automatic send_frame(input logic [15:0] len, input logic [7:0] cmd,
                              input logic [7:0] body [$], input bit crc_ok);
        logic [7:0] c;
        send_byte(cur_start);
        send_byte(len[7:0]);
        send_byte(len[15:8]);
        if (len > MAX_PAYLOAD) return;
        send_byte(cmd);
        c = board.crc_step(8'h00, cmd);
        foreach (body[i]) begin
            send_byte(body[i]);
            c = board.crc_step(c, body[i]);
        end
        if (!crc_ok) c ^= 8'($urandom_range(1, 255));
        send_byte(c);
    endtask

    // Random noise bytes; never the start byte
    task automatic send_noise(input int n);
        logic [7:0] b;
        repeat (n) begin
            do b = 8'($urandom_range(0, 255)); while (b == cur_start);
            send_byte(b);
        end
    endtask

    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) return $urandom_range(0, 4);
        if (r < 9) return $urandom_range(5, MAX_PAYLOAD - 1);
        return MAX_PAYLOAD;
    endfunction

    // Mostly well-formed frames; some bad CRC, oversize, cut-short and noise
    task automatic send_random();
        logic [7:0]  body [$];
        logic [15:0] len;
        int          r;
        int          n;
        r       = $urandom_range(0, 99);
        gap_pct = ($urandom_range(0, 2) == 0) ? 0 : 25;
        if (r < 88 && r >= 80) begin
            if ($urandom_range(0, 1) != 0) len = 16'($urandom_range(MAX_PAYLOAD + 1, 255));
            else len = {8'($urandom_range(1, 255)), 8'($urandom_range(0, 255))};
            send_frame(len, 8'h00, body, 1'b1);
        end else if (r < 93 && r >= 88) begin
            len = 16'($urandom_range(1, MAX_PAYLOAD));
            n   = $urandom_range(0, len - 1);
            repeat (n) body.push_back(8'($urandom_range(0, 255)));
            send_frame(len, 8'($urandom_range(0, 255)), body, 1'($urandom_range(0, 1)));
        end else if (r >= 93) begin
            send_noise($urandom_range(1, 4));
        end else begin
            len = 16'(pick_len());
            repeat (len) body.push_back(8'($urandom_range(0, 255)));
            send_frame(len, 8'($urandom_range(0, 255)), body, r < 70);
        end
    endtask

    initial begin
        logic [7:0] none [$];
        logic [7:0] one_start [$];
        int         rand_end;
        bit         paused;

        board = new();
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part at the reset start byte
        write_start(START_RST);
        gap_pct = 30;
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h55);
        send_frame(16'd0, 8'hFF, none, 1'b1);                 // empty payload, good CRC
        send_frame(16'd0, 8'h00, none, 1'b0);                 // empty payload, bad CRC
        send_frame(16'(MAX_PAYLOAD + 1), 8'h00, none, 1'b1);  // length just too large
        send_frame(16'h0100, 8'h00, none, 1'b1);              // high length byte set
        one_start.push_back(START_RST);
        send_frame(16'd1, 8'h3C, one_start, 1'b1);            // start byte as payload

        // Random part over several start-byte settings
        rand_start = 8'($urandom_range(1, 254));
        rand_end   = n_bytes + RANDOM_BYTES;
        paused     = 1'b0;
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0:       write_start(8'h00);
                1:       write_start(8'hFF);
                2:       write_start(rand_start);
                default: write_start(START_RST);
            endcase
            while (n_bytes < rand_end - (3 - ph) * RANDOM_BYTES / 4) begin
                if (ph == 1 && !paused && n_bytes > rand_end - RANDOM_BYTES / 2) begin
                    drain();
                    paused = 1'b1;
                end
                if (ph == 3 && n_bytes >= rand_end - CALM_TAIL) calm = 1'b1;
                send_random();
            end
        end

        drain();
        $display("sent %0d bytes: %0d frames delivered, %0d CRC errors, %0d results checked",
                 n_bytes, board.n_frames, board.n_crc_err, board.n_checked);
        $display("start bytes AA, 00, FF and %02h; lengths 0 to %0d plus oversize",
                 rand_start, MAX_PAYLOAD);
        if (board.n_fail == 0 && board.outstanding() == 0) begin
            $display("crc8_frame_parser_top regression: pass");
        end else begin
            $display("crc8_frame_parser_top regression: fail");
        end
        $finish;
    end

endmodule
